### rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Command codes, status codes, default widths and the control word that
// travels down the pipeline next to the data.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int CMD_W          = 4;
    localparam int STATUS_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_CONJ    = 4'd4,
        CMD_MODSQ   = 4'd5,
        CMD_MODULUS = 4'd6,
        CMD_NORM    = 4'd7,
        CMD_EQUAL   = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    // control word carried with every item
    typedef struct packed {
        cmd_t cmd;
        logic sat;
        logic eq;
    } ctl_t;

endpackage

`default_nettype wire

### rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: products, sums and the short operations
// Three register stages: operand products, saturated sums plus the
// add/sub/conjugate/compare results, then the scaled multiply and modulus
// squared results and the numerators and radicand for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              command,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ctl_t                          out_ctl,
    output logic signed [DATA_WIDTH-1:0]  out_re,
    output logic signed [DATA_WIDTH-1:0]  out_im,
    output logic signed [2*DATA_WIDTH:0]  out_num_re,
    output logic signed [2*DATA_WIDTH:0]  out_num_im,
    output logic [2*DATA_WIDTH-1:0]       out_sq
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int W1 = W + 1;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int XW = (SW > 65) ? SW : 65;

    localparam logic signed [W-1:0]  MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] MAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] TOP64 = {{(XW-63){1'b0}}, {63{1'b1}}};

    // sum of two products, held below the 64-bit ceiling
    function automatic logic signed [SW-1:0] wlim(input logic signed [SW-1:0] s);
        logic signed [XW-1:0] x;
        x = XW'(s);
        if (x > TOP64)
            return SW'(TOP64);
        return s;
    endfunction

    function automatic logic ovf1(input logic signed [W1-1:0] x);
        return x[W1-1] != x[W1-2];
    endfunction

    function automatic logic signed [W-1:0] fit1(input logic signed [W1-1:0] x);
        if (x[W1-1] != x[W1-2])
            return x[W1-1] ? MIN_W : MAX_W;
        return x[W-1:0];
    endfunction

    function automatic logic ovfs(input logic signed [SW-1:0] x);
        return (x > MAX_S) || (x < MIN_S);
    endfunction

    function automatic logic signed [W-1:0] fits(input logic signed [SW-1:0] x);
        if (x > MAX_S)
            return MAX_W;
        if (x < MIN_S)
            return MIN_W;
        return x[W-1:0];
    endfunction

    // stage 1 registers
    logic                 v1_reg;
    cmd_t                 cmd1_reg;
    logic signed [W-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [PW-1:0] pac_reg, pbd_reg, pad_reg, pbc_reg, psq0_reg, psq1_reg;
    logic signed [PW-1:0] pac_next, pbd_next, pad_next, pbc_next, psq0_next, psq1_next;
    logic signed [W-1:0]  sx0, sx1;

    // stage 2 registers
    logic                 v2_reg;
    ctl_t                 ctl2_reg, ctl2_next;
    logic signed [W-1:0]  re2_reg, im2_reg, re2_next, im2_next;
    logic signed [SW-1:0] sre2_reg, sim2_reg, ssq2_reg, sre2_next, sim2_next, ssq2_next;
    logic signed [W1-1:0] t_re, t_im;

    // stage 3 registers
    logic                 v3_reg;
    ctl_t                 ctl3_reg, ctl3_next;
    logic signed [W-1:0]  re3_reg, im3_reg, re3_next, im3_next;
    logic signed [SW-1:0] nre3_reg, nim3_reg;
    logic [PW-1:0]        sq3_reg;
    logic signed [SW-1:0] sh_re, sh_im, sh_sq;

    logic en1, en2, en3;

    // bubbles collapse: a stage loads when empty or when the next one loads
    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    // stage 1: products; the square unit serves |B|^2 for divide, |A|^2 otherwise
    always_comb
    begin
        sx0       = (cmd_t'(command) == CMD_DIV) ? b_re : a_re;
        sx1       = (cmd_t'(command) == CMD_DIV) ? b_im : a_im;
        pac_next  = a_re * b_re;
        pbd_next  = a_im * b_im;
        pad_next  = a_re * b_im;
        pbc_next  = a_im * b_re;
        psq0_next = sx0 * sx0;
        psq1_next = sx1 * sx1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd1_reg <= cmd_t'(command);
            a1_reg   <= a_re;
            b1_reg   <= a_im;
            c1_reg   <= b_re;
            d1_reg   <= b_im;
            pac_reg  <= pac_next;
            pbd_reg  <= pbd_next;
            pad_reg  <= pad_next;
            pbc_reg  <= pbc_next;
            psq0_reg <= psq0_next;
            psq1_reg <= psq1_next;
        end
    end

    // stage 2: sums and the short operations
    always_comb
    begin
        ctl2_next.cmd = cmd1_reg;
        ctl2_next.sat = 1'b0;
        ctl2_next.eq  = 1'b0;
        re2_next      = '0;
        im2_next      = '0;
        sre2_next     = '0;
        sim2_next     = '0;
        t_re          = '0;
        t_im          = '0;
        ssq2_next     = wlim(SW'(psq0_reg) + SW'(psq1_reg));
        case (cmd1_reg)
            CMD_ADD:
            begin
                t_re          = W1'(a1_reg) + W1'(c1_reg);
                t_im          = W1'(b1_reg) + W1'(d1_reg);
                re2_next      = fit1(t_re);
                im2_next      = fit1(t_im);
                ctl2_next.sat = ovf1(t_re) || ovf1(t_im);
            end
            CMD_SUB:
            begin
                t_re          = W1'(a1_reg) - W1'(c1_reg);
                t_im          = W1'(b1_reg) - W1'(d1_reg);
                re2_next      = fit1(t_re);
                im2_next      = fit1(t_im);
                ctl2_next.sat = ovf1(t_re) || ovf1(t_im);
            end
            CMD_MUL:
            begin
                sre2_next = wlim(SW'(pac_reg) - SW'(pbd_reg));
                sim2_next = wlim(SW'(pad_reg) + SW'(pbc_reg));
            end
            CMD_DIV:
            begin
                sre2_next = wlim(SW'(pac_reg) + SW'(pbd_reg));
                sim2_next = wlim(SW'(pbc_reg) - SW'(pad_reg));
            end
            CMD_CONJ:
            begin
                t_im          = -W1'(b1_reg);
                re2_next      = a1_reg;
                im2_next      = fit1(t_im);
                ctl2_next.sat = ovf1(t_im);
            end
            CMD_NORM:
            begin
                sre2_next = SW'(a1_reg);
                sim2_next = SW'(b1_reg);
            end
            CMD_EQUAL:
            begin
                ctl2_next.eq = (a1_reg == c1_reg) && (b1_reg == d1_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            ctl2_reg <= ctl2_next;
            re2_reg  <= re2_next;
            im2_reg  <= im2_next;
            sre2_reg <= sre2_next;
            sim2_reg <= sim2_next;
            ssq2_reg <= ssq2_next;
        end
    end

    // stage 3: scale the multiply and modulus squared sums, floor rounding
    always_comb
    begin
        ctl3_next = ctl2_reg;
        re3_next  = re2_reg;
        im3_next  = im2_reg;
        sh_re     = sre2_reg >>> F;
        sh_im     = sim2_reg >>> F;
        sh_sq     = ssq2_reg >>> F;
        case (ctl2_reg.cmd)
            CMD_MUL:
            begin
                re3_next      = fits(sh_re);
                im3_next      = fits(sh_im);
                ctl3_next.sat = ovfs(sh_re) || ovfs(sh_im);
            end
            CMD_MODSQ:
            begin
                re3_next      = fits(sh_sq);
                im3_next      = '0;
                ctl3_next.sat = ovfs(sh_sq);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ctl3_reg <= ctl3_next;
            re3_reg  <= re3_next;
            im3_reg  <= im3_next;
            nre3_reg <= sre2_reg;
            nim3_reg <= sim2_reg;
            sq3_reg  <= ssq2_reg[PW-1:0];
        end
    end

    assign out_valid  = v3_reg;
    assign out_ctl    = ctl3_reg;
    assign out_re     = re3_reg;
    assign out_im     = im3_reg;
    assign out_num_re = nre3_reg;
    assign out_num_im = nim3_reg;
    assign out_sq     = sq3_reg;

endmodule

`default_nettype wire

### rtl/core/cau_sqrt.sv
// ----------------------------------------------------------------------------
// cau_sqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence over a 2W-bit radicand.
// A side word rides along unchanged with every item.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_sqrt
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SB_W       = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2*DATA_WIDTH-1:0] rad,
    input  logic [SB_W-1:0]         sb_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [DATA_WIDTH-1:0]   root,
    output logic [SB_W-1:0]         sb_out
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = W + 3;
    localparam int VW = 2 * W;

    logic            v_reg    [W];
    logic [RW-1:0]   rem_reg  [W];
    logic [W-1:0]    root_reg [W];
    logic [VW-1:0]   rad_reg  [W];
    logic [SB_W-1:0] sb_reg   [W];
    wire  [W-1:0]    en;

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic            pv;
        logic [RW-1:0]   prem;
        logic [W-1:0]    proot;
        logic [VW-1:0]   prad;
        logic [SB_W-1:0] psb;
        logic [RW-1:0]   shrem, trial, rem_next;
        logic [W-1:0]    root_next;

        if (i == 0)
        begin : g_head
            assign pv    = in_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = rad;
            assign psb   = sb_in;
        end
        else
        begin : g_body
            assign pv    = v_reg[i-1];
            assign prem  = rem_reg[i-1];
            assign proot = root_reg[i-1];
            assign prad  = rad_reg[i-1];
            assign psb   = sb_reg[i-1];
        end

        if (i == W - 1)
        begin : g_tail
            assign en[i] = !v_reg[i] || !out_stall;
        end
        else
        begin : g_link
            assign en[i] = !v_reg[i] || en[i+1];
        end

        // bring in the next two radicand bits, try root*4+1
        always_comb
        begin
            shrem = {prem[RW-3:0], prad[VW-1 -: 2]};
            trial = {1'b0, proot, 2'b01};
            if (shrem >= trial)
            begin
                rem_next  = shrem - trial;
                root_next = {proot[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shrem;
                root_next = {proot[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en[i])
                v_reg[i] <= pv;
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= prad << 2;
                sb_reg[i]   <= psb;
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[W-1];
    assign root      = root_reg[W-1];
    assign sb_out    = sb_reg[W-1];

endmodule

`default_nettype wire

### rtl/core/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div: pipelined fixed-point divider and result merge
// A setup stage picks the divisor and the overflow check, W restoring
// steps make one quotient bit each for both lanes, and the output
// register merges divide, normalize, modulus and front-end results.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ctl_t                          ctl,
    input  logic signed [DATA_WIDTH-1:0]  early_re,
    input  logic signed [DATA_WIDTH-1:0]  early_im,
    input  logic signed [2*DATA_WIDTH:0]  num_re,
    input  logic signed [2*DATA_WIDTH:0]  num_im,
    input  logic [2*DATA_WIDTH-1:0]       den,
    input  logic [DATA_WIDTH-1:0]         root,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic                          is_equal,
    output logic [STATUS_W-1:0]           status
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * W + 1;
    localparam int DW = 2 * W;
    localparam int RW = 2 * W + 1;
    localparam int NW = 2 * W + F;
    localparam int HW = W + F;
    localparam int CW = (HW > DW) ? HW : DW;

    localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    // index 0 is the setup stage, 1..W the quotient steps
    logic                v_reg    [W+1];
    ctl_t                ctl_reg  [W+1];
    logic signed [W-1:0] ere_reg  [W+1];
    logic signed [W-1:0] eim_reg  [W+1];
    logic [W-1:0]        root_reg [W+1];
    logic [DW-1:0]       d_reg    [W+1];
    logic                dz_reg   [W+1];
    logic                neg_reg  [W+1][2];
    logic                ovf_reg  [W+1][2];
    logic [RW-1:0]       r_reg    [W+1][2];
    logic [W-1:0]        l_reg    [W+1][2];
    logic [W-1:0]        q_reg    [W+1][2];
    wire  [W:0]          en;

    // setup signals
    logic [DW-1:0]       d_next;
    logic                dz_next;
    logic signed [SW-1:0] num  [2];
    logic [SW-1:0]       mag   [2];
    logic [NW-1:0]       nfull [2];
    logic                neg_next [2];
    logic                ovf_next [2];
    logic [RW-1:0]       r_next   [2];
    logic [W-1:0]        l_next   [2];

    // output stage
    logic                fv_reg;
    logic signed [W-1:0] fre_reg, fim_reg, fre_next, fim_next;
    logic                feq_reg;
    status_t             fst_reg, fst_next;
    logic                fen;
    logic [W-1:0]        lim [2];
    logic                qs  [2];
    logic [W-1:0]        qv  [2];

    assign fen = !fv_reg || !out_stall;
    assign in_stall = !en[0];

    for (genvar k = 0; k <= W; k++)
    begin : g_en
        if (k == W)
        begin : g_tail
            assign en[k] = !v_reg[k] || fen;
        end
        else
        begin : g_link
            assign en[k] = !v_reg[k] || en[k+1];
        end
    end

    // setup: divisor choice, magnitudes, scaled numerator and overflow check
    always_comb
    begin
        d_next  = (ctl.cmd == CMD_DIV) ? den : DW'(root);
        dz_next = ((ctl.cmd == CMD_DIV) || (ctl.cmd == CMD_NORM)) && (d_next == '0);
        num[0]  = num_re;
        num[1]  = num_im;
        for (int j = 0; j < 2; j++)
        begin
            neg_next[j] = num[j][SW-1];
            mag[j]      = neg_next[j] ? -num[j] : num[j];
            nfull[j]    = NW'(mag[j][DW-1:0]) << F;
            ovf_next[j] = CW'(nfull[j][NW-1:W]) >= CW'(d_next);
            r_next[j]   = RW'(nfull[j][NW-1:W]);
            l_next[j]   = nfull[j][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en[0])
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0]  <= ctl;
            ere_reg[0]  <= early_re;
            eim_reg[0]  <= early_im;
            root_reg[0] <= root;
            d_reg[0]    <= d_next;
            dz_reg[0]   <= dz_next;
            for (int j = 0; j < 2; j++)
            begin
                neg_reg[0][j] <= neg_next[j];
                ovf_reg[0][j] <= ovf_next[j];
                r_reg[0][j]   <= r_next[j];
                l_reg[0][j]   <= l_next[j];
                q_reg[0][j]   <= '0;
            end
        end
    end

    // quotient steps: shift in one numerator bit, subtract when it fits
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [RW-1:0] shr  [2];
        logic [RW-1:0] r_nx [2];
        logic [W-1:0]  q_nx [2];

        always_comb
        begin
            for (int j = 0; j < 2; j++)
            begin
                shr[j] = {r_reg[k-1][j][RW-2:0], l_reg[k-1][j][W-1]};
                if (shr[j] >= {1'b0, d_reg[k-1]})
                begin
                    r_nx[j] = shr[j] - {1'b0, d_reg[k-1]};
                    q_nx[j] = {q_reg[k-1][j][W-2:0], 1'b1};
                end
                else
                begin
                    r_nx[j] = shr[j];
                    q_nx[j] = {q_reg[k-1][j][W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                ctl_reg[k]  <= ctl_reg[k-1];
                ere_reg[k]  <= ere_reg[k-1];
                eim_reg[k]  <= eim_reg[k-1];
                root_reg[k] <= root_reg[k-1];
                d_reg[k]    <= d_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                for (int j = 0; j < 2; j++)
                begin
                    neg_reg[k][j] <= neg_reg[k-1][j];
                    ovf_reg[k][j] <= ovf_reg[k-1][j];
                    r_reg[k][j]   <= r_nx[j];
                    l_reg[k][j]   <= l_reg[k-1][j] << 1;
                    q_reg[k][j]   <= q_nx[j];
                end
            end
        end
    end

    // merge: signed quotients with saturation, modulus clamp, passthrough
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            lim[j] = neg_reg[W][j] ? MIN_W : MAX_W;
            qs[j]  = ovf_reg[W][j] || (q_reg[W][j] > lim[j]);
            if (qs[j])
                qv[j] = neg_reg[W][j] ? MIN_W : MAX_W;
            else
                qv[j] = neg_reg[W][j] ? -q_reg[W][j] : q_reg[W][j];
        end

        fre_next = ere_reg[W];
        fim_next = eim_reg[W];
        fst_next = ctl_reg[W].sat ? ST_SAT : ST_OK;
        case (ctl_reg[W].cmd)
            CMD_DIV, CMD_NORM:
            begin
                if (dz_reg[W])
                begin
                    fre_next = '0;
                    fim_next = '0;
                    fst_next = ST_DIV_ZERO;
                end
                else
                begin
                    fre_next = qv[0];
                    fim_next = qv[1];
                    fst_next = (qs[0] || qs[1]) ? ST_SAT : ST_OK;
                end
            end
            CMD_MODULUS:
            begin
                fim_next = '0;
                if (root_reg[W][W-1])
                begin
                    fre_next = MAX_W;
                    fst_next = ST_SAT;
                end
                else
                begin
                    fre_next = root_reg[W];
                    fst_next = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (fen)
            fv_reg <= v_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            fre_reg <= fre_next;
            fim_reg <= fim_next;
            feq_reg <= ctl_reg[W].eq;
            fst_reg <= fst_next;
        end
    end

    assign out_valid = fv_reg;
    assign res_re    = fre_reg;
    assign res_im    = fim_reg;
    assign is_equal  = feq_reg;
    assign status    = fst_reg;

endmodule

`default_nettype wire

### rtl/core/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex-number ALU
// Add, subtract, multiply, divide, conjugate, modulus squared, modulus,
// normalize and compare on signed fixed-point complex operands.
//
// Usage:
//   Operation channel op_valid/op_stall carries command and operands A and B
//   (a real scalar is B with a zero imaginary part). Result channel
//   res_valid/res_stall carries res_re, res_im, is_equal and status
//   (ok, divide by zero, saturated). A word moves when valid is high and
//   stall is low.
//   Every command passes the same register stages, in this order:
//   three front stages with the multipliers, DATA_WIDTH square-root stages,
//   one divider setup stage, DATA_WIDTH quotient stages, one output register.
//   Throughput is one word per cycle while no stall holds the pipeline; results leave in order.
//   Reset clears all stage valid bits; no result is pending afterwards.
//   While res_stall is high the output word holds and empty stages below it
//   keep filling; op_stall rises only when every stage holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    output logic                          op_stall,
    input  logic [CMD_W-1:0]              command,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic                          is_equal,
    output logic [STATUS_W-1:0]           status
);

    localparam int W    = DATA_WIDTH;
    localparam int SW   = 2 * W + 1;
    localparam int CTLW = $bits(ctl_t);
    localparam int SB_W = CTLW + 2 * W + 2 * SW + 2 * W;

    // front end to square root
    logic                 fr_valid, fr_stall;
    ctl_t                 fr_ctl;
    logic signed [W-1:0]  fr_re, fr_im;
    logic signed [SW-1:0] fr_nre, fr_nim;
    logic [2*W-1:0]       fr_sq;
    logic [SB_W-1:0]      sb_in, sb_out;

    // square root to divider
    logic                 sq_valid, sq_stall;
    logic [W-1:0]         sq_root;
    ctl_t                 sq_ctl;
    logic signed [W-1:0]  sq_re, sq_im;
    logic signed [SW-1:0] sq_nre, sq_nim;
    logic [2*W-1:0]       sq_den;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (op_valid),
        .in_stall   (op_stall),
        .command    (command),
        .a_re       (a_re),
        .a_im       (a_im),
        .b_re       (b_re),
        .b_im       (b_im),
        .out_valid  (fr_valid),
        .out_stall  (fr_stall),
        .out_ctl    (fr_ctl),
        .out_re     (fr_re),
        .out_im     (fr_im),
        .out_num_re (fr_nre),
        .out_num_im (fr_nim),
        .out_sq     (fr_sq)
    );

    // control word, early results, numerators and the squared sum (radicand or denominator) ride beside the root
    assign sb_in = {fr_ctl, fr_re, fr_im, fr_nre, fr_nim, fr_sq};
    assign {sq_ctl, sq_re, sq_im, sq_nre, sq_nim, sq_den} = sb_out;

    cau_sqrt #(
        .DATA_WIDTH (DATA_WIDTH),
        .SB_W       (SB_W)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fr_valid),
        .in_stall   (fr_stall),
        .rad        (fr_sq),
        .sb_in      (sb_in),
        .out_valid  (sq_valid),
        .out_stall  (sq_stall),
        .root       (sq_root),
        .sb_out     (sb_out)
    );

    cau_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_valid),
        .in_stall   (sq_stall),
        .ctl        (sq_ctl),
        .early_re   (sq_re),
        .early_im   (sq_im),
        .num_re     (sq_nre),
        .num_im     (sq_nim),
        .den        (sq_den),
        .root       (sq_root),
        .out_valid  (res_valid),
        .out_stall  (res_stall),
        .res_re     (res_re),
        .res_im     (res_im),
        .is_equal   (is_equal),
        .status     (status)
    );

endmodule

`default_nettype wire
